[rtl/scaa_pkg.sv]
// ---------------------------------------------------------------------------
// scaa_pkg
// shared widths, beat types and helpers for the segment chop block
// ---------------------------------------------------------------------------
package scaa_pkg;

  // coordinate width, valid range 8 .. 32
  localparam int CoordBits = 16;
  // width of a step register
  localparam int StepBits  = 16;
  // smallest step the chop will use
  localparam logic [StepBits-1:0] MinStep = StepBits'(1024);
  // piece count limit per segment
  localparam int MaxPieces = 64;
  localparam int IdxBits   = $clog2(MaxPieces) + 1;

  // derived datapath widths
  localparam int MulBits   = CoordBits + StepBits;
  localparam int AccBits   = 2 * CoordBits;
  localparam int DstepBits = ((CoordBits > StepBits) ? CoordBits : StepBits) + 1;
  localparam int CntBits   = $clog2(AccBits);

  // configuration register indexes
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegMaxStepX = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegMaxStepY = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [StepBits-1:0]  step_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_beat_t;

  typedef struct packed {
    coord_t piece_start_x;
    coord_t piece_start_y;
    coord_t piece_end_x;
    coord_t piece_end_y;
    logic   last_piece;
  } out_beat_t;

  // step value actually used: small settings are raised to the minimum
  function automatic step_t eff_step(input step_t v);
    eff_step = (v < MinStep) ? MinStep : v;
  endfunction

endpackage

[rtl/segment_chop_by_axis_amplitude.sv]
// ---------------------------------------------------------------------------
// segment_chop_by_axis_amplitude
// splits a line segment into pieces no wider than a set step on either axis
// ---------------------------------------------------------------------------
// One segment is taken at a time. A segment whose X and Y spans both fit in
// their steps leaves as one piece through the check and emit states. Any
// other segment is cut along the dominant axis (larger span-to-step ratio,
// X on a tie) into ceil(span/step) pieces, at most 64. Setup runs three
// bit-serial multiplies (the two ratio cross products and the minor-axis
// increment); each inner breakpoint then needs a bit-serial restoring
// divide of 2*COORD bits, while the final piece goes straight to emit.
// The next segment is accepted once the last piece sits in the output
// register, even if that beat has not yet been taken. Step registers
// below 1024 act as 1024. Write the steps only while idle.
// ---------------------------------------------------------------------------
module segment_chop_by_axis_amplitude (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [scaa_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [scaa_pkg::StepBits-1:0]        cfg_data_i,
  // segment input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  scaa_pkg::in_beat_t                   in_data_i,
  // piece output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output scaa_pkg::out_beat_t                  out_data_o
);

  localparam int C  = scaa_pkg::CoordBits;
  localparam int S  = scaa_pkg::StepBits;
  localparam int MB = scaa_pkg::MulBits;
  localparam int AB = scaa_pkg::AccBits;
  localparam int DB = scaa_pkg::DstepBits;
  localparam int NB = scaa_pkg::CntBits;
  localparam int IB = scaa_pkg::IdxBits;

  // sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StMulA  = 3'd2;
  localparam logic [2:0] StMulB  = 3'd3;
  localparam logic [2:0] StMulC  = 3'd4;
  localparam logic [2:0] StNext  = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StEmit  = 3'd7;

  localparam logic [NB-1:0] MulLast = NB'(S - 1);
  localparam logic [NB-1:0] DivLast = NB'(AB - 1);
  localparam logic [IB-1:0] PieceCap = IB'(scaa_pkg::MaxPieces);

  // configuration
  scaa_pkg::step_t max_step_x_q, max_step_y_q;
  scaa_pkg::step_t stx, sty;

  // control
  logic [2:0]    state_q, state_d;
  logic [NB-1:0] cnt_q, cnt_d;
  logic [IB-1:0] idx_q, idx_d;
  logic          last_q, last_d;
  logic          xdom_q, xdom_d;
  logic          out_valid_q, out_valid_d;

  // held segment and geometry
  scaa_pkg::coord_t sx_q, sy_q, ex_q, ey_q, sx_d, sy_d, ex_d, ey_d;
  scaa_pkg::coord_t prev_x_q, prev_y_q, prev_x_d, prev_y_d;
  scaa_pkg::coord_t ax_q, ay_q, ax_d, ay_d;
  logic             negx_q, negy_q, negx_d, negy_d;
  logic [DB-1:0]    dstep_q, dstep_d;
  logic [AB-1:0]    acc_q, acc_d;
  logic [MB-1:0]    amsd_q, amsd_d;
  logic [MB-1:0]    prod1_q, prod1_d;

  // bit-serial multiplier: product register shifts right, multiplier in low half
  scaa_pkg::coord_t mul_a_q, mul_a_d;
  logic [MB-1:0]    mul_p_q, mul_p_d;
  logic [C:0]       mul_sum;
  logic [MB-1:0]    mul_next;

  // restoring divider: one quotient bit per cycle
  scaa_pkg::coord_t div_r_q, div_r_d;
  logic [AB-1:0]    div_q_q, div_q_d;
  logic [C:0]       div_shift;
  logic             div_fit;
  scaa_pkg::coord_t div_r_next;
  logic [AB-1:0]    div_q_next;

  scaa_pkg::out_beat_t out_q, out_d;

  // working values
  scaa_pkg::coord_t ad, am, am_new, off_x, off_y, pt_x, pt_y;
  scaa_pkg::step_t  sd, sd_new;
  logic             xdom_new;
  logic [DB-1:0]    dstep_n;
  logic [IB-1:0]    idx_n;
  logic [AB-1:0]    acc_n;
  logic             in_acc, out_acc;

  assign stx = scaa_pkg::eff_step(max_step_x_q);
  assign sty = scaa_pkg::eff_step(max_step_y_q);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;

  // step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_x_q <= S'(4096);
      max_step_y_q <= S'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scaa_pkg::RegMaxStepX: max_step_x_q <= cfg_data_i;
        scaa_pkg::RegMaxStepY: max_step_y_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    // axis roles of the held segment
    ad = xdom_q ? ax_q : ay_q;
    am = xdom_q ? ay_q : ax_q;
    sd = xdom_q ? stx : sty;

    // multiplier step
    mul_sum  = {1'b0, mul_p_q[MB-1:S]} + (mul_p_q[0] ? {1'b0, mul_a_q} : '0);
    mul_next = {mul_sum, mul_p_q[S-1:1]};

    // divider step, divisor is the dominant span
    div_shift  = {div_r_q, div_q_q[AB-1]};
    div_fit    = (div_shift >= {1'b0, ad});
    div_r_next = div_fit ? C'(div_shift - {1'b0, ad}) : div_shift[C-1:0];
    div_q_next = {div_q_q[AB-2:0], div_fit};

    // dominance from the two cross products, x wins a tie
    xdom_new = (prod1_q >= mul_next);
    am_new   = xdom_new ? ay_q : ax_q;
    sd_new   = xdom_new ? stx : sty;

    // next breakpoint candidate
    dstep_n = dstep_q + DB'(sd);
    idx_n   = idx_q + IB'(1);
    acc_n   = acc_q + AB'(amsd_q);

    // breakpoint coordinates from dominant step and divided minor offset
    off_x = xdom_q ? dstep_q[C-1:0] : div_q_q[C-1:0];
    off_y = xdom_q ? div_q_q[C-1:0] : dstep_q[C-1:0];
    if (last_q) begin
      pt_x = ex_q;
      pt_y = ey_q;
    end else begin
      pt_x = negx_q ? sx_q - off_x : sx_q + off_x;
      pt_y = negy_q ? sy_q - off_y : sy_q + off_y;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    last_d      = last_q;
    xdom_d      = xdom_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    negx_d      = negx_q;
    negy_d      = negy_q;
    dstep_d     = dstep_q;
    acc_d       = acc_q;
    amsd_d      = amsd_q;
    prod1_d     = prod1_q;
    mul_a_d     = mul_a_q;
    mul_p_d     = mul_p_q;
    div_r_d     = div_r_q;
    div_q_d     = div_q_q;
    out_d       = out_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          sx_d     = in_data_i.start_x;
          sy_d     = in_data_i.start_y;
          ex_d     = in_data_i.end_x;
          ey_d     = in_data_i.end_y;
          prev_x_d = in_data_i.start_x;
          prev_y_d = in_data_i.start_y;
          negx_d   = in_data_i.end_x < in_data_i.start_x;
          negy_d   = in_data_i.end_y < in_data_i.start_y;
          ax_d     = (in_data_i.end_x < in_data_i.start_x) ?
                     in_data_i.start_x - in_data_i.end_x :
                     in_data_i.end_x - in_data_i.start_x;
          ay_d     = (in_data_i.end_y < in_data_i.start_y) ?
                     in_data_i.start_y - in_data_i.end_y :
                     in_data_i.end_y - in_data_i.start_y;
          state_d  = StCheck;
        end
      end
      StCheck: begin
        if (ax_q <= stx && ay_q <= sty) begin
          // fits as is: one piece
          last_d  = 1'b1;
          state_d = StEmit;
        end else begin
          last_d  = 1'b0;
          mul_a_d = ax_q;
          mul_p_d = {{C{1'b0}}, sty};
          cnt_d   = '0;
          state_d = StMulA;
        end
      end
      StMulA: begin
        mul_p_d = mul_next;
        cnt_d   = cnt_q + NB'(1);
        if (cnt_q == MulLast) begin
          prod1_d = mul_next;
          mul_a_d = ay_q;
          mul_p_d = {{C{1'b0}}, stx};
          cnt_d   = '0;
          state_d = StMulB;
        end
      end
      StMulB: begin
        mul_p_d = mul_next;
        cnt_d   = cnt_q + NB'(1);
        if (cnt_q == MulLast) begin
          xdom_d  = xdom_new;
          mul_a_d = am_new;
          mul_p_d = {{C{1'b0}}, sd_new};
          cnt_d   = '0;
          state_d = StMulC;
        end
      end
      StMulC: begin
        mul_p_d = mul_next;
        cnt_d   = cnt_q + NB'(1);
        if (cnt_q == MulLast) begin
          amsd_d  = mul_next;
          dstep_d = '0;
          acc_d   = '0;
          idx_d   = '0;
          state_d = StNext;
        end
      end
      StNext: begin
        if (dstep_n < DB'(ad) && idx_n < PieceCap) begin
          dstep_d = dstep_n;
          idx_d   = idx_n;
          acc_d   = acc_n;
          div_r_d = '0;
          div_q_d = acc_n;
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          last_d  = 1'b1;
          state_d = StEmit;
        end
      end
      StDiv: begin
        div_r_d = div_r_next;
        div_q_d = div_q_next;
        cnt_d   = cnt_q + NB'(1);
        if (cnt_q == DivLast) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.piece_start_x = prev_x_q;
          out_d.piece_start_y = prev_y_q;
          out_d.piece_end_x   = pt_x;
          out_d.piece_end_y   = pt_y;
          out_d.last_piece    = last_q;
          out_valid_d         = 1'b1;
          prev_x_d            = pt_x;
          prev_y_d            = pt_y;
          state_d             = last_q ? StIdle : StNext;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      xdom_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      xdom_q      <= xdom_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    ex_q     <= ex_d;
    ey_q     <= ey_d;
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    negx_q   <= negx_d;
    negy_q   <= negy_d;
    dstep_q  <= dstep_d;
    acc_q    <= acc_d;
    amsd_q   <= amsd_d;
    prod1_q  <= prod1_d;
    mul_a_q  <= mul_a_d;
    mul_p_q  <= mul_p_d;
    div_r_q  <= div_r_d;
    div_q_q  <= div_q_d;
    out_q    <= out_d;
  end

endmodule

[rtl/scaa_checker.sv]
// ---------------------------------------------------------------------------
// scaa_checker
// port-level assertions for the segment chop block
// ---------------------------------------------------------------------------
module scaa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input scaa_pkg::out_beat_t             out_data_o
);

  // end point of the last delivered piece while a segment is open
  logic             cont_q;
  scaa_pkg::coord_t end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q  <= 1'b0;
      end_x_q <= '0;
      end_y_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      cont_q  <= !out_data_o.last_piece;
      end_x_q <= out_data_o.piece_end_x;
      end_y_q <= out_data_o.piece_end_y;
    end
  end

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // one segment at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a beat");

  // pieces chain end to start
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && cont_q |->
      out_data_o.piece_start_x == end_x_q && out_data_o.piece_start_y == end_y_q)
    else $error("piece does not start where the previous one ended");

  // a pending inner piece means the segment is still open
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_piece |-> !in_ready_o)
    else $error("input ready while a segment is open");

endmodule

bind segment_chop_by_axis_amplitude scaa_checker u_scaa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/segment_chop_by_axis_amplitude_tb.sv]
// ---------------------------------------------------------------------------
// segment_chop_by_axis_amplitude_tb
// self-checking bench for the segment chop block
// ---------------------------------------------------------------------------
// Segments are queued by a stimulus process and driven by a clocked driver.
// Every accepted segment is chopped in the bench by its own predictor, and
// the resulting pieces wait in a queue of expected pieces. A clocked monitor
// takes the pieces from the block and compares them field by field, in
// order. Both sides idle at random. The step registers are rewritten only
// while the block is drained, across several settings including the ones
// below the minimum step and the top of the range.
// ---------------------------------------------------------------------------
module segment_chop_by_axis_amplitude_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and block ports
  logic                            clk_i     = 1'b0;
  logic                            rst_ni    = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [scaa_pkg::CfgIdxBits-1:0] cfg_idx   = scaa_pkg::RegMaxStepX;
  scaa_pkg::step_t                 cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  scaa_pkg::in_beat_t              in_beat   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  scaa_pkg::out_beat_t             out_beat;

  // bench copy of the step registers, reset values of the block
  scaa_pkg::step_t step_x = scaa_pkg::step_t'(4096);
  scaa_pkg::step_t step_y = scaa_pkg::step_t'(4096);

  // segments waiting to be driven, pieces waiting to come out
  scaa_pkg::in_beat_t  seg_queue[$];
  scaa_pkg::out_beat_t piece_queue[$];

  int unsigned mismatch_count = 0;
  int unsigned in_hold        = 0;
  int unsigned out_hold       = 0;
  // when set, neither side idles
  bit          steady         = 1'b0;

  segment_chop_by_axis_amplitude i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  // 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // move a coordinate by a magnitude, wrapping at the coordinate width
  function automatic scaa_pkg::coord_t walk(input scaa_pkg::coord_t base,
                                            input longint unsigned mag,
                                            input bit neg);
    return neg ? scaa_pkg::coord_t'(base - mag) : scaa_pkg::coord_t'(base + mag);
  endfunction

  // cut one segment into the pieces the block must emit, queue them in order
  function automatic void chop_segment(input scaa_pkg::in_beat_t seg);
    longint unsigned     stx, sty, ax, ay, ad, am, sd, cnt, dstep, moff, i;
    bit                  negx, negy, xdom;
    scaa_pkg::coord_t    px, py;
    scaa_pkg::out_beat_t pc;
    // settings below the minimum act as the minimum
    stx  = (step_x < scaa_pkg::MinStep) ? scaa_pkg::MinStep : step_x;
    sty  = (step_y < scaa_pkg::MinStep) ? scaa_pkg::MinStep : step_y;
    negx = seg.end_x < seg.start_x;
    negy = seg.end_y < seg.start_y;
    ax   = negx ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
    ay   = negy ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
    cnt  = 1;
    xdom = 1'b0;
    ad   = 1;
    am   = 0;
    sd   = 1;
    if (ax > stx || ay > sty) begin
      // compare span/step ratios by cross products, x wins a tie
      xdom = (ax * sty) >= (ay * stx);
      ad   = xdom ? ax : ay;
      am   = xdom ? ay : ax;
      sd   = xdom ? stx : sty;
      cnt  = (ad + sd - 1) / sd;
      if (cnt > scaa_pkg::MaxPieces) cnt = scaa_pkg::MaxPieces;
    end
    pc.piece_start_x = seg.start_x;
    pc.piece_start_y = seg.start_y;
    pc.last_piece    = 1'b0;
    // inner breakpoints: whole steps on the dominant axis, truncated minor
    for (i = 1; i < cnt; i++) begin
      dstep = i * sd;
      moff  = (am * dstep) / ad;
      px    = walk(seg.start_x, xdom ? dstep : moff, negx);
      py    = walk(seg.start_y, xdom ? moff : dstep, negy);
      pc.piece_end_x = px;
      pc.piece_end_y = py;
      piece_queue.push_back(pc);
      pc.piece_start_x = px;
      pc.piece_start_y = py;
    end
    // final piece always lands on the true end point
    pc.piece_end_x = seg.end_x;
    pc.piece_end_y = seg.end_y;
    pc.last_piece  = 1'b1;
    piece_queue.push_back(pc);
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_piece(input scaa_pkg::out_beat_t got);
    scaa_pkg::out_beat_t want;
    if (piece_queue.size() == 0) begin
      mismatch_count++;
      $display("%0t ns: piece expected none actual %p", $time, got);
      return;
    end
    want = piece_queue.pop_front();
    compare_field("piece_start_x", want.piece_start_x, got.piece_start_x);
    compare_field("piece_start_y", want.piece_start_y, got.piece_start_y);
    compare_field("piece_end_x", want.piece_end_x, got.piece_end_x);
    compare_field("piece_end_y", want.piece_end_y, got.piece_end_y);
    compare_field("last_piece", want.last_piece, got.last_piece);
  endfunction

  // put a span of given length somewhere on one axis, random direction
  function automatic void place_span(input int unsigned span,
                                     output scaa_pkg::coord_t a,
                                     output scaa_pkg::coord_t b);
    int unsigned lo;
    lo = $urandom_range(0, 65535 - span);
    if ($urandom_range(0, 1)) begin
      a = scaa_pkg::coord_t'(lo);
      b = scaa_pkg::coord_t'(lo + span);
    end else begin
      a = scaa_pkg::coord_t'(lo + span);
      b = scaa_pkg::coord_t'(lo);
    end
  endfunction

  // random segment, shaped toward the interesting corners of the chop
  function automatic scaa_pkg::in_beat_t rand_segment();
    scaa_pkg::in_beat_t s;
    int unsigned        ux, uy, kind, t, span;
    ux   = (step_x < scaa_pkg::MinStep) ? scaa_pkg::MinStep : step_x;
    uy   = (step_y < scaa_pkg::MinStep) ? scaa_pkg::MinStep : step_y;
    s    = {$urandom(), $urandom()};
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: begin
        // x span right around the step, y within its step
        span = ux + $urandom_range(0, 2) - 1;
        if (span > 65535) span = 65535;
        place_span(span, s.start_x, s.end_x);
        place_span($urandom_range(0, uy), s.start_y, s.end_y);
      end
      6: begin
        // same on y
        span = uy + $urandom_range(0, 2) - 1;
        if (span > 65535) span = 65535;
        place_span(span, s.start_y, s.end_y);
        place_span($urandom_range(0, ux), s.start_x, s.end_x);
      end
      7: begin
        // axis-parallel
        if ($urandom_range(0, 1)) s.end_x = s.start_x;
        else s.end_y = s.start_y;
      end
      8: begin
        // short segment
        place_span($urandom_range(0, 300), s.start_x, s.end_x);
        place_span($urandom_range(0, 300), s.start_y, s.end_y);
      end
      9: begin
        // equal span-to-step ratios on both axes
        t = $urandom_range(1, 65535 / ((ux > uy) ? ux : uy));
        place_span(ux * t, s.start_x, s.end_x);
        place_span(uy * t, s.start_y, s.end_y);
      end
      default: begin
        // anywhere in the coordinate space
      end
    endcase
    return s;
  endfunction

  // driver: one beat in flight, payload held until taken, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
      in_hold   = 0;
    end else begin
      if (in_valid && in_ready) begin
        chop_segment(in_beat);
        in_hold = idle_len();
      end else if (!in_valid && in_hold > 0) begin
        in_hold--;
      end
      if (in_valid && !in_ready) begin
        // beat still waiting, keep it
      end else if (in_hold == 0 && seg_queue.size() > 0) begin
        in_beat  <= seg_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each taken piece, drop ready for random stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_hold   = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_piece(out_beat);
        out_hold = idle_len();
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready <= (out_hold == 0);
    end
  end

  // write one step register, keep the bench copy in line
  task automatic write_step(input logic [scaa_pkg::CfgIdxBits-1:0] idx,
                            input scaa_pkg::step_t value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == scaa_pkg::RegMaxStepX) step_x = value;
    else step_y = value;
  endtask

  task automatic write_steps(input scaa_pkg::step_t sx, input scaa_pkg::step_t sy);
    write_step(scaa_pkg::RegMaxStepX, sx);
    write_step(scaa_pkg::RegMaxStepY, sy);
  endtask

  task automatic queue_seg(input int unsigned sx, input int unsigned sy,
                           input int unsigned ex, input int unsigned ey);
    scaa_pkg::in_beat_t s;
    s.start_x = scaa_pkg::coord_t'(sx);
    s.start_y = scaa_pkg::coord_t'(sy);
    s.end_x   = scaa_pkg::coord_t'(ex);
    s.end_y   = scaa_pkg::coord_t'(ey);
    seg_queue.push_back(s);
  endtask

  // wait until every segment is taken and every piece has come out,
  // then give the block a little slack before anything else happens
  task automatic wait_drained();
    do @(negedge clk_i);
    while (seg_queue.size() != 0 || in_valid || piece_queue.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int              p;
    int              n;
    scaa_pkg::step_t nx;
    scaa_pkg::step_t ny;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset steps of 4096
    queue_seg(0, 0, 0, 0);                  // zero length
    queue_seg(65535, 65535, 65535, 65535);  // zero length at the top corner
    queue_seg(0, 0, 4096, 4096);            // spans exactly at the step
    queue_seg(0, 0, 4097, 4096);            // x just over, two pieces
    queue_seg(0, 0, 4096, 4097);            // y just over
    queue_seg(0, 0, 65535, 65535);          // ratio tie, x dominant
    queue_seg(65535, 65535, 0, 0);          // both axes descending
    queue_seg(0, 65535, 65535, 0);
    queue_seg(65535, 0, 0, 65535);
    queue_seg(100, 0, 200, 60000);          // y dominant, small x drift
    queue_seg(50000, 1000, 0, 1003);        // x descending, tiny minor
    queue_seg(1000, 50000, 1003, 0);        // minor truncation toward zero
    queue_seg(0, 0, 0, 65535);              // pure y
    queue_seg(65535, 0, 0, 0);              // pure x descending
    queue_seg(43690, 21845, 21845, 43690);  // alternating bit patterns
    wait_drained();

    // steps below range, both act as 1024; longest chops
    write_steps(scaa_pkg::step_t'(0), scaa_pkg::step_t'(1023));
    queue_seg(0, 0, 65535, 0);              // 64 pieces
    queue_seg(0, 65535, 65535, 0);          // 64 pieces, tie
    queue_seg(0, 0, 1024, 1024);            // pass-through at the minimum
    queue_seg(0, 0, 1025, 1024);
    queue_seg(12345, 54321, 54321, 12345);
    wait_drained();

    // top of the range: everything passes through
    write_steps(scaa_pkg::step_t'(65535), scaa_pkg::step_t'(65535));
    queue_seg(0, 65535, 65535, 0);
    queue_seg(65535, 0, 0, 65535);
    wait_drained();

    // random phases across several step settings
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin nx = scaa_pkg::step_t'(4096);  ny = scaa_pkg::step_t'(4096);  end
        1: begin nx = scaa_pkg::step_t'(1024);  ny = scaa_pkg::step_t'(65535); end
        2: begin nx = scaa_pkg::step_t'(65535); ny = scaa_pkg::step_t'(1024);  end
        3: begin nx = scaa_pkg::step_t'(1024);  ny = scaa_pkg::step_t'(1024);  end
        4: begin
          nx = scaa_pkg::step_t'($urandom_range(1024, 65535));
          ny = scaa_pkg::step_t'($urandom_range(1024, 65535));
        end
        5: begin
          nx = scaa_pkg::step_t'($urandom_range(0, 1023));
          ny = scaa_pkg::step_t'($urandom);
        end
        default: begin nx = scaa_pkg::step_t'(2000); ny = scaa_pkg::step_t'(3000); end
      endcase
      // one phase runs back to back with no idling at all
      steady = (p == 3);
      write_steps(nx, ny);
      for (n = 0; n < 27; n++) seg_queue.push_back(rand_segment());
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && piece_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
